[rtl/sarc_pkg.sv]
// Shared payload types and fixed constants for the shortest-arc quaternion core.
`default_nettype none

package sarc_pkg;

  localparam int IN_W     = 16;  // width of each input vector component
  localparam int OUT_W    = 16;  // width of each quaternion component
  localparam int MARGIN_W = 11;  // width of the antiparallel margin register

  typedef struct packed {
    logic signed [IN_W-1:0] start_x;
    logic signed [IN_W-1:0] start_y;
    logic signed [IN_W-1:0] start_z;
    logic signed [IN_W-1:0] dest_x;
    logic signed [IN_W-1:0] dest_y;
    logic signed [IN_W-1:0] dest_z;
  } sarc_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] quat_w;
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_z;
    logic                    opposite_case;
    logic                    degenerate_input;
  } sarc_out_t;

endpackage

`default_nettype wire

[rtl/shortest_arc_quaternion_core.sv]
// Top level of the shortest-arc quaternion core: stages, root and divider chains.
// Takes a start and a destination vector (signed integers of any scale) and returns
// the unit quaternion (w,x,y,z, signed with FRAC_BITS fraction bits) turning the
// normalized start onto the normalized destination. One word is taken every clock
// while the result side keeps up; a stalled output freezes the whole pipe. Besides
// its stage registers, the pipe holds the two 32-cell root chains, the 31-cell
// unit-vector divider and the FRAC_BITS+1-cell quaternion divider. Pairs
// whose dot lies within cfg margin of -1 come out as a half-turn (w = 0) with
// opposite_case set; a zero vector gives the identity with degenerate_input set.
// The margin register must only be written while the pipe is empty.
`default_nettype none

module shortest_arc_quaternion_core
  import sarc_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sarc_in_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sarc_out_t           out_data,
  input  logic                cfg_we,
  input  logic [MARGIN_W-1:0] cfg_wdata
);

  localparam int UNIT_FB  = 30;           // fraction bits of the internal unit vectors
  localparam int SQ_STEPS = 32;           // root bits per square root chain
  localparam int DA_STEPS = UNIT_FB + 1;  // quotient bits of the unit-vector divide
  localparam int DB_STEPS = FRAC_BITS + 1;
  localparam logic [63:0] ONE60    = 64'd1 << 60;
  localparam logic [63:0] TENTH_SQ = ((64'd1 << 60) + 64'd99) / 64'd100;  // 0.01, rounded up
  localparam logic [63:0] MARG_MAX = 64'd1 << (FRAC_BITS + 1);
  localparam logic [31:0] ONE_Q    = 32'd1 << FRAC_BITS;

  // ---------------------------------------------------------------- stage types
  typedef struct packed {
    logic [2:0][31:0] ma;     // start magnitudes, scaled so the largest is >= 2^30 (unless all zero)
    logic [2:0][31:0] mb;     // dest magnitudes, same scaling
    logic [2:0]       sa;
    logic [2:0]       sb;
    logic             degen;
  } nrm_t;

  typedef struct packed {
    nrm_t             v;
    logic [2:0][63:0] qa;
    logic [2:0][63:0] qb;
  } sq_t;

  typedef struct packed {
    nrm_t        v;
    logic [63:0] l2a;
    logic [63:0] l2b;
  } ln_t;

  typedef struct packed {
    logic [2:0] sa;
    logic [2:0] sb;
    logic       degen;
  } sgn_t;

  typedef struct packed {
    logic [5:0][63:0] num;
    logic [5:0][63:0] den;
    sgn_t             s;
  } dva_t;

  typedef struct packed {
    logic [2:0][31:0] na;
    logic [2:0][31:0] nb;
    logic             degen;
  } unit_t;

  typedef struct packed {
    logic [2:0][63:0] dt;
    logic [5:0][63:0] cp;
    logic [1:0][63:0] lq;
    logic [2:0][31:0] na;
    logic             degen;
  } prod_t;

  typedef struct packed {
    logic [63:0]      dot;
    logic [2:0][63:0] cr;
    logic [63:0]      l2;
    logic [2:0][31:0] na;
    logic             degen;
  } sum_t;

  typedef struct packed {
    logic             opp;
    logic [63:0]      t;
    logic [2:0][31:0] axm;
    logic [2:0]       axn;
    logic [2:0][63:0] cr;
    logic             degen;
  } sel_t;

  typedef struct packed {
    logic             opp;
    logic [63:0]      t;
    logic [2:0][31:0] axm;
    logic [2:0]       axn;
    logic             axzero;
    logic [2:0][63:0] crm;
    logic [2:0]       crn;
    logic             degen;
  } axs_t;

  typedef struct packed {
    axs_t             v;
    logic [2:0][63:0] aq;
  } axq_t;

  typedef struct packed {
    logic [63:0] x;
    axs_t        v;
  } rtb_t;

  typedef struct packed {
    logic [31:0] w;
    logic [2:0]  neg;
    logic [2:0]  sat;
    logic        opp;
    logic        axzero;
    logic        degen;
  } fin_t;

  typedef struct packed {
    logic [2:0][63:0] num;
    logic [63:0]      den;
    fin_t             f;
  } dvb_t;

  localparam int NRM_W = $bits(nrm_t);
  localparam int SGN_W = $bits(sgn_t);
  localparam int AXS_W = $bits(axs_t);
  localparam int FIN_W = $bits(fin_t);

  // ---------------------------------------------------------------- helpers
  // shift that brings the largest magnitude to at least 2^30
  function automatic logic [4:0] norm_shift(input logic [31:0] mx);
    logic [4:0] p;
    p = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (mx[k]) p = 5'(k);
    end
    return (p >= 5'd30) ? 5'd0 : (5'd30 - p);
  endfunction

  function automatic logic [31:0] mag_in(input logic [IN_W-1:0] v);
    logic signed [32:0] e;
    e = 33'($signed(v));
    return e[32] ? 32'(-e) : e[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // signed 32 x 32 product; low 64 bits of the sign-extended operands
  function automatic logic [63:0] smul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
    return p;
  endfunction

  // ---------------------------------------------------------------- flow control
  logic        adv;          // whole pipe moves when the output slot frees up
  logic        out_valid_r, out_valid_nxt;
  sarc_out_t   out_r, out_nxt;
  logic [13:1] vld_r, vld_nxt;

  logic [MARGIN_W-1:0] cfg_margin_r;

  assign adv       = ~out_valid_r | out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_margin_r <= '0;
    end else if (cfg_we) begin
      cfg_margin_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- stage registers
  nrm_t  p1_r,  p1_nxt;
  sq_t   p2_r,  p2_nxt;
  ln_t   p3_r,  p3_nxt;
  dva_t  p4_r,  p4_nxt;
  unit_t p5_r,  p5_nxt;
  prod_t p6_r,  p6_nxt;
  sum_t  p7_r,  p7_nxt;
  sel_t  p8_r,  p8_nxt;
  axs_t  p9_r,  p9_nxt;
  axq_t  p10_r, p10_nxt;
  rtb_t  p11_r, p11_nxt;
  dvb_t  p12_r, p12_nxt;
  dvb_t  p13_r, p13_nxt;

  // chain wiring
  logic [SQ_STEPS:0]                  qa_vld;
  logic [SQ_STEPS:0][1:0][63:0]       qa_rem;
  logic [SQ_STEPS:0][1:0][31:0]       qa_root;
  logic [SQ_STEPS:0][NRM_W-1:0]       qa_sb;
  nrm_t                               qa_end;

  logic [DA_STEPS:0]                  da_vld;
  logic [DA_STEPS:0][5:0][63:0]       da_rem;
  logic [DA_STEPS:0][5:0][63:0]       da_den;
  logic [DA_STEPS:0][5:0][DA_STEPS-1:0] da_quo;
  logic [DA_STEPS:0][SGN_W-1:0]       da_sb;
  sgn_t                               da_end;

  logic [SQ_STEPS:0]                  qb_vld;
  logic [SQ_STEPS:0][0:0][63:0]       qb_rem;
  logic [SQ_STEPS:0][0:0][31:0]       qb_root;
  logic [SQ_STEPS:0][AXS_W-1:0]       qb_sb;
  axs_t                               qb_end;

  logic [DB_STEPS:0]                  db_vld;
  logic [DB_STEPS:0][2:0][63:0]       db_rem;
  logic [DB_STEPS:0][2:0][63:0]       db_den;
  logic [DB_STEPS:0][2:0][31:0]       db_quo;
  logic [DB_STEPS:0][FIN_W-1:0]       db_sb;
  fin_t                               db_end;

  // ---------------------------------------------------------------- p1: block scaling
  logic [2:0][31:0] in_ma, in_mb;
  logic [31:0]      mxa, mxb;
  logic [4:0]       sha, shb;

  always_comb begin
    in_ma[0] = mag_in(in_data.start_x);
    in_ma[1] = mag_in(in_data.start_y);
    in_ma[2] = mag_in(in_data.start_z);
    in_mb[0] = mag_in(in_data.dest_x);
    in_mb[1] = mag_in(in_data.dest_y);
    in_mb[2] = mag_in(in_data.dest_z);
    mxa = in_ma[0];
    mxb = in_mb[0];
    for (int k = 1; k < 3; k++) begin
      if (in_ma[k] > mxa) mxa = in_ma[k];
      if (in_mb[k] > mxb) mxb = in_mb[k];
    end
    sha = norm_shift(mxa);
    shb = norm_shift(mxb);
    for (int k = 0; k < 3; k++) begin
      p1_nxt.ma[k] = in_ma[k] << sha;
      p1_nxt.mb[k] = in_mb[k] << shb;
    end
    p1_nxt.sa    = {in_data.start_z[IN_W-1], in_data.start_y[IN_W-1],
                    in_data.start_x[IN_W-1]};
    p1_nxt.sb    = {in_data.dest_z[IN_W-1], in_data.dest_y[IN_W-1],
                    in_data.dest_x[IN_W-1]};
    p1_nxt.degen = (mxa == 32'd0) | (mxb == 32'd0);
  end

  // ---------------------------------------------------------------- p2: squares
  always_comb begin
    p2_nxt.v = p1_r;
    for (int k = 0; k < 3; k++) begin
      p2_nxt.qa[k] = {32'd0, p1_r.ma[k]} * {32'd0, p1_r.ma[k]};
      p2_nxt.qb[k] = {32'd0, p1_r.mb[k]} * {32'd0, p1_r.mb[k]};
    end
  end

  // ---------------------------------------------------------------- p3: squared lengths
  always_comb begin
    p3_nxt.v   = p2_r.v;
    p3_nxt.l2a = p2_r.qa[0] + p2_r.qa[1] + p2_r.qa[2];
    p3_nxt.l2b = p2_r.qb[0] + p2_r.qb[1] + p2_r.qb[2];
  end

  // ---------------------------------------------------------------- root chain A (lengths)
  assign qa_vld[0]  = vld_r[3];
  assign qa_rem[0]  = {p3_r.l2b, p3_r.l2a};
  assign qa_root[0] = '0;
  assign qa_sb[0]   = p3_r.v;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_qa
    sarc_sqrt_cell #(
      .LANES (2),
      .SHIFT (SQ_STEPS - 1 - j),
      .SB_W  (NRM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (qa_vld[j]),
      .in_rem   (qa_rem[j]),
      .in_root  (qa_root[j]),
      .in_sb    (qa_sb[j]),
      .out_vld  (qa_vld[j+1]),
      .out_rem  (qa_rem[j+1]),
      .out_root (qa_root[j+1]),
      .out_sb   (qa_sb[j+1])
    );
  end

  assign qa_end = qa_sb[SQ_STEPS];

  // ---------------------------------------------------------------- p4: rounded divide setup
  // lanes 0..2 carry the start vector, 3..5 the destination
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p4_nxt.num[k]   = ({32'd0, qa_end.ma[k]} << UNIT_FB)
                        + {33'd0, qa_root[SQ_STEPS][0][31:1]};
      p4_nxt.den[k]   = {32'd0, qa_root[SQ_STEPS][0]};
      p4_nxt.num[k+3] = ({32'd0, qa_end.mb[k]} << UNIT_FB)
                        + {33'd0, qa_root[SQ_STEPS][1][31:1]};
      p4_nxt.den[k+3] = {32'd0, qa_root[SQ_STEPS][1]};
    end
    p4_nxt.s.sa    = qa_end.sa;
    p4_nxt.s.sb    = qa_end.sb;
    p4_nxt.s.degen = qa_end.degen;
  end

  // ---------------------------------------------------------------- divider chain A
  assign da_vld[0] = vld_r[4];
  assign da_rem[0] = p4_r.num;
  assign da_den[0] = p4_r.den;
  assign da_quo[0] = '0;
  assign da_sb[0]  = p4_r.s;

  for (genvar j = 0; j < DA_STEPS; j++) begin : g_da
    sarc_div_cell #(
      .LANES (6),
      .SHIFT (DA_STEPS - 1 - j),
      .QW    (DA_STEPS),
      .SB_W  (SGN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (da_vld[j]),
      .in_rem  (da_rem[j]),
      .in_den  (da_den[j]),
      .in_quo  (da_quo[j]),
      .in_sb   (da_sb[j]),
      .out_vld (da_vld[j+1]),
      .out_rem (da_rem[j+1]),
      .out_den (da_den[j+1]),
      .out_quo (da_quo[j+1]),
      .out_sb  (da_sb[j+1])
    );
  end

  assign da_end = da_sb[DA_STEPS];

  // ---------------------------------------------------------------- p5: signed unit vectors
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p5_nxt.na[k] = da_end.sa[k] ? (32'd0 - {1'b0, da_quo[DA_STEPS][k]})
                                  : {1'b0, da_quo[DA_STEPS][k]};
      p5_nxt.nb[k] = da_end.sb[k] ? (32'd0 - {1'b0, da_quo[DA_STEPS][k+3]})
                                  : {1'b0, da_quo[DA_STEPS][k+3]};
    end
    p5_nxt.degen = da_end.degen;
  end

  // ---------------------------------------------------------------- p6: products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p6_nxt.dt[k] = smul(p5_r.na[k], p5_r.nb[k]);
    end
    p6_nxt.cp[0] = smul(p5_r.na[1], p5_r.nb[2]);
    p6_nxt.cp[1] = smul(p5_r.na[2], p5_r.nb[1]);
    p6_nxt.cp[2] = smul(p5_r.na[2], p5_r.nb[0]);
    p6_nxt.cp[3] = smul(p5_r.na[0], p5_r.nb[2]);
    p6_nxt.cp[4] = smul(p5_r.na[0], p5_r.nb[1]);
    p6_nxt.cp[5] = smul(p5_r.na[1], p5_r.nb[0]);
    p6_nxt.lq[0] = smul(p5_r.na[0], p5_r.na[0]);
    p6_nxt.lq[1] = smul(p5_r.na[1], p5_r.na[1]);
    p6_nxt.na    = p5_r.na;
    p6_nxt.degen = p5_r.degen;
  end

  // ---------------------------------------------------------------- p7: dot and cross
  always_comb begin
    p7_nxt.dot   = p6_r.dt[0] + p6_r.dt[1] + p6_r.dt[2];
    p7_nxt.cr[0] = p6_r.cp[0] - p6_r.cp[1];
    p7_nxt.cr[1] = p6_r.cp[2] - p6_r.cp[3];
    p7_nxt.cr[2] = p6_r.cp[4] - p6_r.cp[5];
    p7_nxt.l2    = p6_r.lq[0] + p6_r.lq[1];
    p7_nxt.na    = p6_r.na;
    p7_nxt.degen = p6_r.degen;
  end

  // ---------------------------------------------------------------- p8: opposite test, axis pick
  logic [63:0] marg, thr, dotc;

  always_comb begin
    marg = ({53'd0, cfg_margin_r} > MARG_MAX) ? MARG_MAX : {53'd0, cfg_margin_r};
    thr  = (marg << (60 - FRAC_BITS)) - ONE60;
    dotc = ($signed(p7_r.dot) > $signed(ONE60)) ? ONE60 : p7_r.dot;
    p8_nxt.opp = $signed(p7_r.dot) <= $signed(thr);
    p8_nxt.t   = (ONE60 + dotc) << 1;
    if (p7_r.l2 >= TENTH_SQ) begin
      // Z cross start = (-y, x, 0)
      p8_nxt.axm[0] = mag32(p7_r.na[1]);
      p8_nxt.axn[0] = ~p7_r.na[1][31] & (p7_r.na[1] != 32'd0);
      p8_nxt.axm[1] = mag32(p7_r.na[0]);
      p8_nxt.axn[1] = p7_r.na[0][31];
      p8_nxt.axm[2] = 32'd0;
      p8_nxt.axn[2] = 1'b0;
    end else begin
      // start almost along Z: X cross start = (0, -z, y)
      p8_nxt.axm[0] = 32'd0;
      p8_nxt.axn[0] = 1'b0;
      p8_nxt.axm[1] = mag32(p7_r.na[2]);
      p8_nxt.axn[1] = ~p7_r.na[2][31] & (p7_r.na[2] != 32'd0);
      p8_nxt.axm[2] = mag32(p7_r.na[1]);
      p8_nxt.axn[2] = p7_r.na[1][31];
    end
    p8_nxt.cr    = p7_r.cr;
    p8_nxt.degen = p7_r.degen;
  end

  // ---------------------------------------------------------------- p9: axis scaling, |cross|
  logic [31:0] mxx;
  logic [4:0]  shx;

  always_comb begin
    mxx = p8_r.axm[0];
    for (int k = 1; k < 3; k++) begin
      if (p8_r.axm[k] > mxx) mxx = p8_r.axm[k];
    end
    shx = norm_shift(mxx);
    p9_nxt.opp    = p8_r.opp;
    p9_nxt.t      = p8_r.t;
    p9_nxt.axn    = p8_r.axn;
    p9_nxt.axzero = mxx == 32'd0;
    for (int k = 0; k < 3; k++) begin
      p9_nxt.axm[k] = p8_r.axm[k] << shx;
      p9_nxt.crm[k] = p8_r.cr[k][63] ? (64'd0 - p8_r.cr[k]) : p8_r.cr[k];
      p9_nxt.crn[k] = p8_r.cr[k][63];
    end
    p9_nxt.degen = p8_r.degen;
  end

  // ---------------------------------------------------------------- p10, p11: root operand
  always_comb begin
    p10_nxt.v = p9_r;
    for (int k = 0; k < 3; k++) begin
      p10_nxt.aq[k] = {32'd0, p9_r.axm[k]} * {32'd0, p9_r.axm[k]};
    end
  end

  always_comb begin
    p11_nxt.v = p10_r.v;
    p11_nxt.x = p10_r.v.opp ? (p10_r.aq[0] + p10_r.aq[1] + p10_r.aq[2]) : p10_r.v.t;
  end

  // ---------------------------------------------------------------- root chain B
  // s = sqrt(2(1+dot)) on the normal path, axis length on the half-turn path
  assign qb_vld[0]  = vld_r[11];
  assign qb_rem[0]  = p11_r.x;
  assign qb_root[0] = '0;
  assign qb_sb[0]   = p11_r.v;

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_qb
    sarc_sqrt_cell #(
      .LANES (1),
      .SHIFT (SQ_STEPS - 1 - j),
      .SB_W  (AXS_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_vld   (qb_vld[j]),
      .in_rem   (qb_rem[j]),
      .in_root  (qb_root[j]),
      .in_sb    (qb_sb[j]),
      .out_vld  (qb_vld[j+1]),
      .out_rem  (qb_rem[j+1]),
      .out_root (qb_root[j+1]),
      .out_sb   (qb_sb[j+1])
    );
  end

  assign qb_end = qb_sb[SQ_STEPS];

  // ---------------------------------------------------------------- p12: quotient setup
  logic [63:0] s64, wr;

  always_comb begin
    s64 = {32'd0, qb_root[SQ_STEPS][0]};
    wr  = (s64 + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    p12_nxt.den = qb_end.opp ? s64 : (s64 << (30 - FRAC_BITS));
    for (int k = 0; k < 3; k++) begin
      p12_nxt.num[k]   = qb_end.opp ? (({32'd0, qb_end.axm[k]} << FRAC_BITS) + (s64 >> 1))
                                    : (qb_end.crm[k] + (p12_nxt.den >> 1));
      p12_nxt.f.neg[k] = qb_end.opp ? qb_end.axn[k] : qb_end.crn[k];
    end
    if (qb_end.opp) begin
      p12_nxt.f.w = 32'd0;
    end else begin
      p12_nxt.f.w = (wr > {32'd0, ONE_Q}) ? ONE_Q : wr[31:0];
    end
    p12_nxt.f.sat    = '0;
    p12_nxt.f.opp    = qb_end.opp;
    p12_nxt.f.axzero = qb_end.axzero;
    p12_nxt.f.degen  = qb_end.degen;
  end

  // ---------------------------------------------------------------- p13: saturation check
  // quotient reaches 2^(FRAC_BITS+1) or more: clamp, the chain only covers the low bits
  always_comb begin
    p13_nxt = p12_r;
    for (int k = 0; k < 3; k++) begin
      p13_nxt.f.sat[k] = (p12_r.num[k] >> (FRAC_BITS + 1)) >= p12_r.den;
    end
  end

  // ---------------------------------------------------------------- divider chain B
  assign db_vld[0] = vld_r[13];
  assign db_rem[0] = p13_r.num;
  assign db_den[0] = {p13_r.den, p13_r.den, p13_r.den};
  assign db_quo[0] = '0;
  assign db_sb[0]  = p13_r.f;

  for (genvar j = 0; j < DB_STEPS; j++) begin : g_db
    sarc_div_cell #(
      .LANES (3),
      .SHIFT (FRAC_BITS - j),
      .QW    (32),
      .SB_W  (FIN_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .in_vld  (db_vld[j]),
      .in_rem  (db_rem[j]),
      .in_den  (db_den[j]),
      .in_quo  (db_quo[j]),
      .in_sb   (db_sb[j]),
      .out_vld (db_vld[j+1]),
      .out_rem (db_rem[j+1]),
      .out_den (db_den[j+1]),
      .out_quo (db_quo[j+1]),
      .out_sb  (db_sb[j+1])
    );
  end

  assign db_end = db_sb[DB_STEPS];

  // ---------------------------------------------------------------- output word
  logic [2:0][31:0] qv, sv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qv[k] = (db_end.sat[k] || (db_quo[DB_STEPS][k] > ONE_Q)) ? ONE_Q : db_quo[DB_STEPS][k];
      if (db_end.opp && db_end.axzero) qv[k] = 32'd0;
      sv[k] = db_end.neg[k] ? (32'd0 - qv[k]) : qv[k];
    end
    if (db_end.degen) begin
      out_nxt.quat_w           = ONE_Q[OUT_W-1:0];
      out_nxt.quat_x           = '0;
      out_nxt.quat_y           = '0;
      out_nxt.quat_z           = '0;
      out_nxt.opposite_case    = 1'b0;
      out_nxt.degenerate_input = 1'b1;
    end else begin
      out_nxt.quat_w           = db_end.w[OUT_W-1:0];
      out_nxt.quat_x           = sv[0][OUT_W-1:0];
      out_nxt.quat_y           = sv[1][OUT_W-1:0];
      out_nxt.quat_z           = sv[2][OUT_W-1:0];
      out_nxt.opposite_case    = db_end.opp;
      out_nxt.degenerate_input = 1'b0;
    end
  end

  // ---------------------------------------------------------------- valid tracking
  always_comb begin
    vld_nxt[1]    = in_valid;
    vld_nxt[2]    = vld_r[1];
    vld_nxt[3]    = vld_r[2];
    vld_nxt[4]    = qa_vld[SQ_STEPS];
    vld_nxt[5]    = da_vld[DA_STEPS];
    vld_nxt[6]    = vld_r[5];
    vld_nxt[7]    = vld_r[6];
    vld_nxt[8]    = vld_r[7];
    vld_nxt[9]    = vld_r[8];
    vld_nxt[10]   = vld_r[9];
    vld_nxt[11]   = vld_r[10];
    vld_nxt[12]   = qb_vld[SQ_STEPS];
    vld_nxt[13]   = vld_r[12];
    out_valid_nxt = db_vld[DB_STEPS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      p4_r  <= p4_nxt;
      p5_r  <= p5_nxt;
      p6_r  <= p6_nxt;
      p7_r  <= p7_nxt;
      p8_r  <= p8_nxt;
      p9_r  <= p9_nxt;
      p10_r <= p10_nxt;
      p11_r <= p11_nxt;
      p12_r <= p12_nxt;
      p13_r <= p13_nxt;
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/sarc_sqrt_cell.sv]
// One cell of the integer square root chain: settles one root bit per lane.
`default_nettype none

module sarc_sqrt_cell #(
  parameter int LANES = 1,
  parameter int SHIFT = 0,
  parameter int SB_W  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [LANES-1:0][63:0] in_rem,
  input  logic [LANES-1:0][31:0] in_root,
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_vld,
  output logic [LANES-1:0][63:0] out_rem,
  output logic [LANES-1:0][31:0] out_root,
  output logic [SB_W-1:0]        out_sb
);

  logic                   vld_r;
  logic [LANES-1:0][63:0] rem_r, rem_nxt;
  logic [LANES-1:0][31:0] root_r, root_nxt;
  logic [SB_W-1:0]        sb_r;
  logic [LANES-1:0][65:0] inc;
  logic [LANES-1:0]       fits;

  // rem holds value - root^2; trying bit SHIFT costs (root << (SHIFT+1)) + 4^SHIFT
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      inc[l]      = ({34'd0, in_root[l]} << (SHIFT + 1)) + (66'd1 << (2 * SHIFT));
      fits[l]     = {2'b00, in_rem[l]} >= inc[l];
      rem_nxt[l]  = fits[l] ? (in_rem[l] - inc[l][63:0]) : in_rem[l];
      root_nxt[l] = fits[l] ? (in_root[l] | (32'd1 << SHIFT)) : in_root[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      sb_r   <= in_sb;
    end
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_sb   = sb_r;

endmodule

`default_nettype wire

[rtl/sarc_div_cell.sv]
// One cell of the restoring divider chain: settles one quotient bit per lane.
`default_nettype none

module sarc_div_cell #(
  parameter int LANES = 1,
  parameter int SHIFT = 0,
  parameter int QW    = 32,
  parameter int SB_W  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [LANES-1:0][63:0] in_rem,
  input  logic [LANES-1:0][63:0] in_den,
  input  logic [LANES-1:0][QW-1:0] in_quo,
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_vld,
  output logic [LANES-1:0][63:0] out_rem,
  output logic [LANES-1:0][63:0] out_den,
  output logic [LANES-1:0][QW-1:0] out_quo,
  output logic [SB_W-1:0]        out_sb
);

  logic                     vld_r;
  logic [LANES-1:0][63:0]   rem_r, rem_nxt;
  logic [LANES-1:0][63:0]   den_r;
  logic [LANES-1:0][QW-1:0] quo_r, quo_nxt;
  logic [SB_W-1:0]          sb_r;
  logic [LANES-1:0][95:0]   dsh;
  logic [LANES-1:0]         fits;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      dsh[l]     = {32'd0, in_den[l]} << SHIFT;
      fits[l]    = {32'd0, in_rem[l]} >= dsh[l];
      rem_nxt[l] = fits[l] ? (in_rem[l] - dsh[l][63:0]) : in_rem[l];
      quo_nxt[l] = fits[l] ? (in_quo[l] | (QW'(1) << SHIFT)) : in_quo[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= in_den;
      quo_r <= quo_nxt;
      sb_r  <= in_sb;
    end
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_den = den_r;
  assign out_quo = quo_r;
  assign out_sb  = sb_r;

endmodule

`default_nettype wire
